// ===== rtl/dmi_pkg.sv =====
package dmi_pkg;

  // Haplotype code fields.
  localparam logic [15:0] CodeDel = 16'hF000;
  localparam logic [3:0]  NibSub  = 4'hE;
  localparam logic [15:0] HomLimit = 16'd21845;
  localparam logic [15:0] HalfQ16  = 16'd32768;

  // Base codes.
  localparam logic [2:0] BaseOther = 3'd4;
  localparam logic [2:0] BaseDash  = 3'd5;

  // Configuration register defaults.
  localparam logic [15:0] MutRateReset   = 16'd66;
  localparam logic [15:0] IndelFracReset = 16'd9830;
  localparam logic [15:0] IndelExtReset  = 16'd19661;

  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_MUT_RATE   = 2'd0,
    CFG_INDEL_FRAC = 2'd1,
    CFG_INDEL_EXT  = 2'd2,
    CFG_HAPLOID    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  base_char;
    logic        seq_start;
    logic [15:0] rand_extend;
    logic [15:0] rand_mutate;
    logic [15:0] rand_kind;
    logic [15:0] rand_substitute;
    logic [15:0] rand_zygosity;
    logic [15:0] rand_side;
    logic [15:0] rand_del_or_ins;
    logic [7:0]  ins_bases;
    logic [47:0] ins_extend_draws;
  } in_word_t;

  typedef struct packed {
    logic [15:0] hap1_code;
    logic [15:0] hap2_code;
  } out_word_t;

  // ASCII character to base code.
  function automatic logic [2:0] base_code(input logic [7:0] ch);
    logic [2:0] code;
    unique case (ch)
      8'h41, 8'h61: code = 3'd0;
      8'h43, 8'h63: code = 3'd1;
      8'h47, 8'h67: code = 3'd2;
      8'h54, 8'h74: code = 3'd3;
      8'h2D:        code = BaseDash;
      default:      code = BaseOther;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/diploid_mutation_injector_top.sv =====
// Channel  | Direction | Handshake                   | Word
// input    | in        | in_valid_i / in_ready_o     | in_word_i  (dmi_pkg::in_word_t)
// output   | out       | out_valid_o / out_ready_i   | out_word_o (dmi_pkg::out_word_t)
// config   | in        | cfg_we_i, no wait           | cfg_idx_i, cfg_data_i
//
// One word per cycle unless the output stalls; a word passes both registers in order.
// An input register feeds one pass of compare and select logic into the output register.
// The open deletion mask updates when a word moves from the input register to the output.
// Reset clears the mask, both valid flags and the configuration to its defaults.
// An output stall holds the output word; the input register takes one more word only if it is empty.
module diploid_mutation_injector_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dmi_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dmi_pkg::out_word_t            out_word_o,
  input  logic                          cfg_we_i,
  input  dmi_pkg::cfg_reg_e             cfg_idx_i,
  input  logic [dmi_pkg::CfgDataW-1:0]  cfg_data_i
);
  import dmi_pkg::*;

  logic [15:0] mutation_rate_q, indel_share_q, indel_ext_q;
  logic        haploid_q;

  logic        s1_valid_q;
  in_word_t    s1_word_q;
  logic        out_valid_q;
  out_word_t   out_word_q;
  logic [1:0]  mask_q, mask_d;
  out_word_t   res_d;

  logic        out_free, advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mutation_rate_q <= MutRateReset;
      indel_share_q   <= IndelFracReset;
      indel_ext_q     <= IndelExtReset;
      haploid_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MUT_RATE:   mutation_rate_q <= cfg_data_i[15:0];
        CFG_INDEL_FRAC: indel_share_q   <= cfg_data_i[15:0];
        CFG_INDEL_EXT:  indel_ext_q     <= cfg_data_i[15:0];
        CFG_HAPLOID:    haploid_q       <= cfg_data_i[0];
        default:        haploid_q       <= haploid_q;
      endcase
    end
  end

  // Pipeline handshake.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && out_free;
  assign in_ready_o = rst_ni && (!s1_valid_q || advance);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_word_q <= in_word_i;
    end
  end

  // Mutation decision for the word in the input register.
  logic [2:0]  c;
  logic [15:0] c16;
  logic [1:0]  mask_eff;
  logic        hom, side1, ext_hit;
  logic [17:0] sub_prod;
  logic [1:0]  sub_base;
  logic [2:0]  ins_len;
  logic [7:0]  ins_seq;
  logic [15:0] event_code;

  always_comb begin
    c        = base_code(s1_word_q.base_char);
    c16      = {13'd0, c};
    mask_eff = s1_word_q.seq_start ? 2'b00 : mask_q;
    ext_hit  = s1_word_q.rand_extend < indel_ext_q;
    hom      = haploid_q || (s1_word_q.rand_zygosity < HomLimit);
    side1    = s1_word_q.rand_side < HalfQ16;
    sub_prod = {2'b00, s1_word_q.rand_substitute} * 18'd3;
    sub_base = c[1:0] + sub_prod[17:16] + 2'd1;

    // Insertion length from the leading extension draws.
    if (!(s1_word_q.ins_extend_draws[15:0] < indel_ext_q)) begin
      ins_len = 3'd1;
    end else if (!(s1_word_q.ins_extend_draws[31:16] < indel_ext_q)) begin
      ins_len = 3'd2;
    end else if (!(s1_word_q.ins_extend_draws[47:32] < indel_ext_q)) begin
      ins_len = 3'd3;
    end else begin
      ins_len = 3'd4;
    end
    unique case (ins_len)
      3'd1:    ins_seq = {6'd0, s1_word_q.ins_bases[7:6]};
      3'd2:    ins_seq = {4'd0, s1_word_q.ins_bases[7:4]};
      3'd3:    ins_seq = {2'd0, s1_word_q.ins_bases[7:2]};
      default: ins_seq = s1_word_q.ins_bases;
    endcase

    res_d.hap1_code = c16;
    res_d.hap2_code = c16;
    mask_d          = mask_eff;
    event_code      = c16;

    if (mask_eff != 2'b00 && ext_hit) begin
      // Open deletion carries on.
      if (mask_eff[0]) res_d.hap1_code = CodeDel | c16;
      if (mask_eff[1]) res_d.hap2_code = CodeDel | c16;
    end else begin
      mask_d = 2'b00;
      if (!c[2] && (s1_word_q.rand_mutate < mutation_rate_q)) begin
        if (!(s1_word_q.rand_kind < indel_share_q)) begin
          event_code = {NibSub, 10'd0, sub_base};
        end else if (s1_word_q.rand_del_or_ins < HalfQ16) begin
          event_code = CodeDel;
          mask_d     = hom ? 2'b11 : (side1 ? 2'b01 : 2'b10);
        end else begin
          event_code = {1'b0, ins_len, ins_seq, 1'b0, c};
        end
        if (hom || side1)  res_d.hap1_code = event_code;
        if (hom || !side1) res_d.hap2_code = event_code;
      end
    end
  end

  // Output register and deletion mask.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mask_q      <= 2'b00;
    end else begin
      if (out_free) out_valid_q <= s1_valid_q;
      if (advance)  mask_q      <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== rtl/dmi_checker.sv =====
module dmi_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input dmi_pkg::out_word_t out_word_o
);
  import dmi_pkg::*;

  // A stalled output word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // The input side only backs up behind a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input not ready without an output stall");

  // Output valid rises only for an input accept that has passed the input and output registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("output word without a matching input accept");

  // Nothing is offered right after reset.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid straight out of reset");

endmodule

bind diploid_mutation_injector_top dmi_checker u_dmi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
